FILE: rtl/fpmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpmi_pkg: shared types and constants of the page map insert core
// Widths, microcode word layout, sequencer codes and the entry update helper.
// ----------------------------------------------------------------------------
package fpmi_pkg;

	// pool and table geometry
	localparam int POOL_TABLES   = 64;
	localparam int TABLE_ENTRIES = 512;
	localparam int POOL_W        = $clog2(POOL_TABLES);
	localparam int NFREE_W       = $clog2(POOL_TABLES + 1);
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = POOL_W + SLOT_W;

	// field widths
	localparam int ENTRY_W       = 64;
	localparam int FRAME_W       = 40;
	localparam int VPAGE_W       = 36;
	localparam int PAGE_SHIFT    = 12;
	localparam int LEAF_TABLE_W  = 6;
	localparam int CREATED_W     = 2;

	// walk depth above the leaf level
	localparam int LEVELS        = 3;
	localparam int LEVEL_W       = 2;

	localparam int FLAG_PRESENT  = 0;

	localparam int STEP_W        = 4;

	typedef enum logic [STEP_W-1:0] {
		S_INIT_CLR  = 4'd0,
		S_IDLE      = 4'd1,
		S_RD        = 4'd2,
		S_LATCH     = 4'd3,
		S_ALLOC_CHK = 4'd4,
		S_ALLOC     = 4'd5,
		S_CLEAR     = 4'd6,
		S_LINK      = 4'd7,
		S_FOLLOW    = 4'd8,
		S_NEXT      = 4'd9,
		S_LEAF_RD   = 4'd10,
		S_LEAF_WR   = 4'd11,
		S_FAIL      = 4'd12,
		S_DONE      = 4'd13,
		S_RET       = 4'd14
	} step_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_CLR_MORE_ALL,
		C_CLR_MORE_TBL,
		C_PRESENT,
		C_POOL_EMPTY,
		C_PIDX_BAD,
		C_MORE_LEVELS,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		A_WALK,
		A_ALL,
		A_TBL,
		A_LEAF
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_ZERO,
		WD_LINK,
		WD_LEAF
	} wd_sel_t;

	typedef enum logic [1:0] {
		CLR_HOLD,
		CLR_INC,
		CLR_ZERO
	} clr_op_t;

	typedef struct packed {
		logic      accept;
		logic      emit;
		logic      mem_we;
		addr_sel_t addr_sel;
		wd_sel_t   wd_sel;
		clr_op_t   clr_op;
		logic      latch_entry;
		logic      alloc;
		logic      follow;
		logic      take_fresh;
		logic      level_inc;
		logic      set_fail;
		cond_t     cond;
		step_t     target;
	} uword_t;

	typedef struct packed {
		logic no_input;
		logic clr_more_all;
		logic clr_more_tbl;
		logic present;
		logic pool_empty;
		logic pidx_bad;
		logic more_levels;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic                    status;
		logic [CREATED_W-1:0]    tables_created;
		logic [LEAF_TABLE_W-1:0] leaf_table;
		logic [SLOT_W-1:0]       leaf_slot;
	} res_t;

	// Replace the frame address, set present and read/write, keep the rest.
	function automatic logic [ENTRY_W-1:0] with_frame(input logic [ENTRY_W-1:0] entry,
			input logic [FRAME_W-1:0] frame);
		logic [ENTRY_W-1:0] e;
		begin
			e = entry;
			e[PAGE_SHIFT +: FRAME_W] = frame;
			e[1:0] = 2'b11;
			return e;
		end
	endfunction

endpackage
`default_nettype wire

FILE: rtl/fpmi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpmi_ram: single-port table store
// One access a cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module fpmi_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 15
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [0:(1 << ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fpmi_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpmi_seq: microcode sequencer
// Step counter, control store and conditional jump on datapath flags.
// ----------------------------------------------------------------------------
module fpmi_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fpmi_pkg::flags_t flags,
	output fpmi_pkg::uword_t     ctrl
);

	// control store
	function automatic fpmi_pkg::uword_t ucode(input fpmi_pkg::step_t s);
		fpmi_pkg::uword_t w;
		begin
			w = '0;
			unique case (s)
				fpmi_pkg::S_INIT_CLR: begin
					w.mem_we   = 1'b1;
					w.addr_sel = fpmi_pkg::A_ALL;
					w.wd_sel   = fpmi_pkg::WD_ZERO;
					w.clr_op   = fpmi_pkg::CLR_INC;
					w.cond     = fpmi_pkg::C_CLR_MORE_ALL;
					w.target   = fpmi_pkg::S_INIT_CLR;
				end
				fpmi_pkg::S_IDLE: begin
					w.accept = 1'b1;
					w.cond   = fpmi_pkg::C_NO_INPUT;
					w.target = fpmi_pkg::S_IDLE;
				end
				fpmi_pkg::S_RD: begin
					w.addr_sel = fpmi_pkg::A_WALK;
				end
				fpmi_pkg::S_LATCH: begin
					w.latch_entry = 1'b1;
					w.cond        = fpmi_pkg::C_PRESENT;
					w.target      = fpmi_pkg::S_FOLLOW;
				end
				fpmi_pkg::S_ALLOC_CHK: begin
					w.cond   = fpmi_pkg::C_POOL_EMPTY;
					w.target = fpmi_pkg::S_FAIL;
				end
				fpmi_pkg::S_ALLOC: begin
					w.alloc  = 1'b1;
					w.clr_op = fpmi_pkg::CLR_ZERO;
				end
				fpmi_pkg::S_CLEAR: begin
					w.mem_we   = 1'b1;
					w.addr_sel = fpmi_pkg::A_TBL;
					w.wd_sel   = fpmi_pkg::WD_ZERO;
					w.clr_op   = fpmi_pkg::CLR_INC;
					w.cond     = fpmi_pkg::C_CLR_MORE_TBL;
					w.target   = fpmi_pkg::S_CLEAR;
				end
				fpmi_pkg::S_LINK: begin
					w.mem_we     = 1'b1;
					w.addr_sel   = fpmi_pkg::A_WALK;
					w.wd_sel     = fpmi_pkg::WD_LINK;
					w.take_fresh = 1'b1;
					w.cond       = fpmi_pkg::C_ALWAYS;
					w.target     = fpmi_pkg::S_NEXT;
				end
				fpmi_pkg::S_FOLLOW: begin
					w.follow = 1'b1;
					w.cond   = fpmi_pkg::C_PIDX_BAD;
					w.target = fpmi_pkg::S_FAIL;
				end
				fpmi_pkg::S_NEXT: begin
					w.level_inc = 1'b1;
					w.cond      = fpmi_pkg::C_MORE_LEVELS;
					w.target    = fpmi_pkg::S_RD;
				end
				fpmi_pkg::S_LEAF_RD: begin
					w.addr_sel = fpmi_pkg::A_LEAF;
				end
				fpmi_pkg::S_LEAF_WR: begin
					w.mem_we   = 1'b1;
					w.addr_sel = fpmi_pkg::A_LEAF;
					w.wd_sel   = fpmi_pkg::WD_LEAF;
					w.cond     = fpmi_pkg::C_ALWAYS;
					w.target   = fpmi_pkg::S_DONE;
				end
				fpmi_pkg::S_FAIL: begin
					w.set_fail = 1'b1;
				end
				fpmi_pkg::S_DONE: begin
					w.emit   = 1'b1;
					w.cond   = fpmi_pkg::C_OUT_BUSY;
					w.target = fpmi_pkg::S_DONE;
				end
				fpmi_pkg::S_RET: begin
					w.cond   = fpmi_pkg::C_ALWAYS;
					w.target = fpmi_pkg::S_IDLE;
				end
				default: begin
					w.cond   = fpmi_pkg::C_ALWAYS;
					w.target = fpmi_pkg::S_IDLE;
				end
			endcase
			return w;
		end
	endfunction

	fpmi_pkg::step_t upc_q;
	fpmi_pkg::step_t upc_d;
	logic            jump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= fpmi_pkg::S_INIT_CLR;
		end else begin
			upc_q <= upc_d;
		end
	end

	always_comb begin
		ctrl = ucode(upc_q);
		unique case (ctrl.cond)
			fpmi_pkg::C_NEVER:        jump = 1'b0;
			fpmi_pkg::C_ALWAYS:       jump = 1'b1;
			fpmi_pkg::C_NO_INPUT:     jump = flags.no_input;
			fpmi_pkg::C_CLR_MORE_ALL: jump = flags.clr_more_all;
			fpmi_pkg::C_CLR_MORE_TBL: jump = flags.clr_more_tbl;
			fpmi_pkg::C_PRESENT:      jump = flags.present;
			fpmi_pkg::C_POOL_EMPTY:   jump = flags.pool_empty;
			fpmi_pkg::C_PIDX_BAD:     jump = flags.pidx_bad;
			fpmi_pkg::C_MORE_LEVELS:  jump = flags.more_levels;
			fpmi_pkg::C_OUT_BUSY:     jump = flags.out_busy;
			default:                  jump = 1'b0;
		endcase
		if (jump) begin
			upc_d = ctrl.target;
		end else begin
			upc_d = fpmi_pkg::step_t'(upc_q + 4'd1);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fpmi_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpmi_dpath: walk datapath
// Request registers, allocator, clear counter, address and write data muxing.
// ----------------------------------------------------------------------------
module fpmi_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fpmi_pkg::uword_t              ctrl,
	input  wire logic                          in_valid,
	input  wire logic [fpmi_pkg::VPAGE_W-1:0]  virt_page,
	input  wire logic [fpmi_pkg::FRAME_W-1:0]  phys_frame,
	input  wire logic                          cfg_we,
	input  wire logic [fpmi_pkg::FRAME_W-1:0]  cfg_wdata,
	input  wire logic                          out_free,
	output fpmi_pkg::flags_t                   flags,
	output fpmi_pkg::res_t                     res
);

	localparam int AW = fpmi_pkg::ADDR_W;
	localparam int SW = fpmi_pkg::SLOT_W;
	localparam int PW = fpmi_pkg::POOL_W;
	localparam int FW = fpmi_pkg::FRAME_W;

	logic [FW-1:0]                      base_q;
	logic [fpmi_pkg::VPAGE_W-1:0]       vpage_q;
	logic [FW-1:0]                      pframe_q;
	logic [PW-1:0]                      table_q;
	logic [PW-1:0]                      fresh_q;
	logic [fpmi_pkg::NFREE_W-1:0]       next_free_q;
	logic [AW-1:0]                      clr_q;
	logic [fpmi_pkg::LEVEL_W-1:0]       level_q;
	logic [fpmi_pkg::CREATED_W-1:0]     created_q;
	logic                               fail_q;
	logic [fpmi_pkg::ENTRY_W-1:0]       entry_q;

	logic                               mem_we;
	logic [AW-1:0]                      mem_addr;
	logic [fpmi_pkg::ENTRY_W-1:0]       mem_wdata;
	logic [fpmi_pkg::ENTRY_W-1:0]       mem_rdata;
	logic [SW-1:0]                      walk_idx;
	logic [FW-1:0]                      frame_diff;
	logic                               take_in;

	assign take_in    = ctrl.accept & in_valid;
	assign frame_diff = entry_q[fpmi_pkg::PAGE_SHIFT +: FW] - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_free_q <= fpmi_pkg::NFREE_W'(1);
			clr_q       <= '0;
			level_q     <= '0;
			created_q   <= '0;
			fail_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			case (ctrl.clr_op)
				fpmi_pkg::CLR_INC:  clr_q <= AW'(clr_q + 1'b1);
				fpmi_pkg::CLR_ZERO: clr_q <= '0;
				default:            clr_q <= clr_q;
			endcase
			if (take_in) begin
				level_q   <= '0;
				created_q <= '0;
				fail_q    <= 1'b0;
			end else begin
				if (ctrl.level_inc) begin
					level_q <= fpmi_pkg::LEVEL_W'(level_q + 1'b1);
				end
				if (ctrl.alloc) begin
					created_q <= fpmi_pkg::CREATED_W'(created_q + 1'b1);
				end
				if (ctrl.set_fail) begin
					fail_q <= 1'b1;
				end
			end
			if (ctrl.alloc) begin
				next_free_q <= fpmi_pkg::NFREE_W'(next_free_q + 1'b1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			vpage_q  <= virt_page;
			pframe_q <= phys_frame;
			table_q  <= '0;
		end else if (ctrl.follow) begin
			table_q <= frame_diff[PW-1:0];
		end else if (ctrl.take_fresh) begin
			table_q <= fresh_q;
		end
		if (ctrl.alloc) begin
			fresh_q <= next_free_q[PW-1:0];
		end
		if (ctrl.latch_entry) begin
			entry_q <= mem_rdata;
		end
	end

	// index of the current level
	always_comb begin
		unique case (level_q)
			2'd0:    walk_idx = vpage_q[3*SW +: SW];
			2'd1:    walk_idx = vpage_q[2*SW +: SW];
			2'd2:    walk_idx = vpage_q[SW +: SW];
			default: walk_idx = vpage_q[SW +: SW];
		endcase
	end

	always_comb begin
		mem_we = ctrl.mem_we;
		unique case (ctrl.addr_sel)
			fpmi_pkg::A_WALK: mem_addr = {table_q, walk_idx};
			fpmi_pkg::A_ALL:  mem_addr = clr_q;
			fpmi_pkg::A_TBL:  mem_addr = {fresh_q, clr_q[SW-1:0]};
			fpmi_pkg::A_LEAF: mem_addr = {table_q, vpage_q[SW-1:0]};
			default:          mem_addr = clr_q;
		endcase
		unique case (ctrl.wd_sel)
			fpmi_pkg::WD_LINK: mem_wdata = fpmi_pkg::with_frame(entry_q,
						FW'(base_q + FW'(fresh_q)));
			fpmi_pkg::WD_LEAF: mem_wdata = fpmi_pkg::with_frame(mem_rdata, pframe_q);
			default:           mem_wdata = '0;
		endcase
	end

	fpmi_ram #(
		.DATA_W (fpmi_pkg::ENTRY_W),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		flags.no_input     = ~in_valid;
		flags.clr_more_all = (clr_q != {AW{1'b1}});
		flags.clr_more_tbl = (clr_q[SW-1:0] != {SW{1'b1}});
		flags.present      = mem_rdata[fpmi_pkg::FLAG_PRESENT];
		flags.pool_empty   = (next_free_q >= fpmi_pkg::NFREE_W'(fpmi_pkg::POOL_TABLES));
		flags.pidx_bad     = (frame_diff >= FW'(fpmi_pkg::POOL_TABLES));
		flags.more_levels  = (level_q != fpmi_pkg::LEVEL_W'(fpmi_pkg::LEVELS - 1));
		flags.out_busy     = ~out_free;

		res.status         = fail_q;
		res.tables_created = created_q;
		res.leaf_table     = fail_q ? '0 : fpmi_pkg::LEAF_TABLE_W'(table_q);
		res.leaf_slot      = fail_q ? '0 : vpage_q[SW-1:0];
	end

endmodule
`default_nettype wire

FILE: rtl/four_level_page_map_insert_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_level_page_map_insert_core: four-level page table insert engine
// Maps one virtual page to one physical frame per request word, walking a
// radix table held in an on-chip pool of 64 tables of 512 entries.
//
// Input channel (in_valid / in_stall): virt_page, phys_frame. A word is taken
// only while the sequencer is idle; in_stall is high otherwise.
// Output channel (out_valid / out_stall): status, tables_created, leaf_table,
// leaf_slot, one word per request from an output register. A held result does
// not block the next walk, only the moment that walk wants to hand its result.
// cfg_we / cfg_wdata write the pool base frame; write it only while idle.
//
// Each level reads its entry and follows a present link; a missing table is
// taken from the pool, zeroed one entry a cycle, and linked. The leaf entry
// is then read and rewritten and the result loaded; a dry pool or a link
// outside the pool ends the walk there. The next word is taken after the
// result is loaded. After reset the whole store (32768 entries) is zeroed,
// one entry a cycle, with in_stall high until done. Configuration writes are
// taken at any time.
// ----------------------------------------------------------------------------
module four_level_page_map_insert_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fpmi_pkg::FRAME_W-1:0]        cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [fpmi_pkg::VPAGE_W-1:0]        virt_page,
	input  wire logic [fpmi_pkg::FRAME_W-1:0]        phys_frame,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     status,
	output logic [fpmi_pkg::CREATED_W-1:0]           tables_created,
	output logic [fpmi_pkg::LEAF_TABLE_W-1:0]        leaf_table,
	output logic [fpmi_pkg::SLOT_W-1:0]              leaf_slot
);

	fpmi_pkg::uword_t ctrl;
	fpmi_pkg::flags_t flags;
	fpmi_pkg::res_t   res;
	fpmi_pkg::res_t   res_q;
	logic             out_valid_q;
	logic             out_free;

	// The sequencer only opens the input while it sits in its idle step.
	assign in_stall = ~ctrl.accept;

	// Output register is free when empty or being drained this cycle.
	assign out_free = ~out_valid_q | ~out_stall;

	fpmi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	fpmi_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.in_valid   (in_valid),
		.virt_page  (virt_page),
		.phys_frame (phys_frame),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_free   (out_free),
		.flags      (flags),
		.res        (res)
	);

	// Result word: load when the done step finds the register free, drop
	// when the receiver takes it, hold while it stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign tables_created = res_q.tables_created;
	assign leaf_table     = res_q.leaf_table;
	assign leaf_slot      = res_q.leaf_slot;

endmodule
`default_nettype wire
